// ===== rtl/c6502eu_pkg.sv =====
// ============================================================================
// c6502eu_pkg - shared types and constants of the 6502 execute unit
// Operation classes, decoded control word, architectural state and the
// result record passed between the decoder, the datapath and the top level.
// ============================================================================
package c6502eu_pkg;

    // Internal flag positions (packed six-bit flag word)
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 4;
    localparam int unsigned FLAG_N = 5;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [5:0] FLAGS_RESET = 6'b000100;
    localparam logic       STACK_PAGE  = 1'b1;     // page one prefix of the stack address

    // Stack access codes on the result
    localparam logic [1:0] STACK_NONE = 2'd0;
    localparam logic [1:0] STACK_PUSH = 2'd1;
    localparam logic [1:0] STACK_POP  = 2'd2;

    typedef enum logic [5:0] {
        OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY,
        OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC,
        OP_CMP, OP_CPX, OP_CPY, OP_BIT,
        OP_SHIFT_A, OP_SHIFT_M, OP_INC, OP_DEC,
        OP_INX, OP_INY, OP_DEX, OP_DEY,
        OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS,
        OP_PHA, OP_PHP, OP_PLA, OP_PLP,
        OP_FLAG, OP_NOP, OP_BRANCH, OP_UNSUP
    } op_class_t;

    // Shift kinds, taken from opcode bits 6:5
    localparam logic [1:0] SHIFT_ASL = 2'd0;
    localparam logic [1:0] SHIFT_ROL = 2'd1;
    localparam logic [1:0] SHIFT_LSR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    typedef struct packed {
        op_class_t  op;
        logic [1:0] shift_kind;
        logic [2:0] flag_idx;    // flag written by set/clear, tested by a branch
        logic       flag_val;    // value written, or value the branch tests for
    } dec_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] idx_x;
        logic [7:0] idx_y;
        logic [7:0] sp;
        logic [5:0] flags;
    } arch_t;

    typedef struct packed {
        logic [7:0]        write_data;
        logic              write_enable;
        logic [8:0]        stack_address;
        logic [1:0]        stack_access;
        logic              branch_taken;
        logic signed [7:0] branch_offset;
        logic [7:0]        status_byte;
        logic              unsupported;
    } res_t;

endpackage

// ===== rtl/c6502eu_decode.sv =====
// ============================================================================
// c6502eu_decode - opcode decoder
// Maps a documented 6502 opcode to its operation class and control fields;
// every other opcode, and the non-branch control transfers, decode as unsupported.
// ============================================================================
module c6502eu_decode (
    input  logic [7:0]          opcode,
    output c6502eu_pkg::dec_t   dec
);
    import c6502eu_pkg::*;

    // Decode the opcode byte
    always_comb begin
        dec.op         = OP_UNSUP;
        dec.shift_kind = opcode[6:5];
        dec.flag_idx   = 3'(FLAG_C);
        dec.flag_val   = opcode[5];
        case (opcode)
            8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: dec.op = OP_LDA;
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE:                      dec.op = OP_LDX;
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC:                      dec.op = OP_LDY;
            8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91:        dec.op = OP_STA;
            8'h86, 8'h96, 8'h8E:                                    dec.op = OP_STX;
            8'h84, 8'h94, 8'h8C:                                    dec.op = OP_STY;
            8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: dec.op = OP_ORA;
            8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: dec.op = OP_AND;
            8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: dec.op = OP_EOR;
            8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: dec.op = OP_ADC;
            8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: dec.op = OP_SBC;
            8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: dec.op = OP_CMP;
            8'hE0, 8'hE4, 8'hEC:                                    dec.op = OP_CPX;
            8'hC0, 8'hC4, 8'hCC:                                    dec.op = OP_CPY;
            8'h24, 8'h2C:                                           dec.op = OP_BIT;
            8'h0A, 8'h2A, 8'h4A, 8'h6A:                             dec.op = OP_SHIFT_A;
            8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
            8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: dec.op = OP_SHIFT_M;
            8'hE6, 8'hF6, 8'hEE, 8'hFE:                             dec.op = OP_INC;
            8'hC6, 8'hD6, 8'hCE, 8'hDE:                             dec.op = OP_DEC;
            8'hE8: dec.op = OP_INX;
            8'hC8: dec.op = OP_INY;
            8'hCA: dec.op = OP_DEX;
            8'h88: dec.op = OP_DEY;
            8'hAA: dec.op = OP_TAX;
            8'hA8: dec.op = OP_TAY;
            8'h8A: dec.op = OP_TXA;
            8'h98: dec.op = OP_TYA;
            8'hBA: dec.op = OP_TSX;
            8'h9A: dec.op = OP_TXS;
            8'h48: dec.op = OP_PHA;
            8'h08: dec.op = OP_PHP;
            8'h68: dec.op = OP_PLA;
            8'h28: dec.op = OP_PLP;
            8'h18, 8'h38: begin
                dec.op       = OP_FLAG;
                dec.flag_idx = 3'(FLAG_C);
            end
            8'h58, 8'h78: begin
                dec.op       = OP_FLAG;
                dec.flag_idx = 3'(FLAG_I);
            end
            8'hB8: begin
                dec.op       = OP_FLAG;
                dec.flag_idx = 3'(FLAG_V);
                dec.flag_val = 1'b0;
            end
            8'hD8, 8'hF8: begin
                dec.op       = OP_FLAG;
                dec.flag_idx = 3'(FLAG_D);
            end
            8'hEA: dec.op = OP_NOP;
            // Branches: bits 7:6 pick the flag, bit 5 the value tested for
            8'h10, 8'h30: begin
                dec.op       = OP_BRANCH;
                dec.flag_idx = 3'(FLAG_N);
            end
            8'h50, 8'h70: begin
                dec.op       = OP_BRANCH;
                dec.flag_idx = 3'(FLAG_V);
            end
            8'h90, 8'hB0: begin
                dec.op       = OP_BRANCH;
                dec.flag_idx = 3'(FLAG_C);
            end
            8'hD0, 8'hF0: begin
                dec.op       = OP_BRANCH;
                dec.flag_idx = 3'(FLAG_Z);
            end
            default: dec.op = OP_UNSUP;
        endcase
    end

endmodule

// ===== rtl/c6502eu_alu.sv =====
// ============================================================================
// c6502eu_alu - execute datapath
// Computes the next architectural state and the result record of one
// decoded instruction from the current state and the operand byte.
// ============================================================================
module c6502eu_alu (
    input  c6502eu_pkg::dec_t   dec,
    input  logic [7:0]          operand_value,
    input  c6502eu_pkg::arch_t  cur,
    output c6502eu_pkg::arch_t  nxt,
    output c6502eu_pkg::res_t   res
);
    import c6502eu_pkg::*;

    logic       carry_in;
    logic [7:0] add_rhs;
    logic [8:0] add_sum;
    logic       add_ovf;
    logic [7:0] cmp_lhs;
    logic [8:0] cmp_diff;
    logic [7:0] shift_src;
    logic [7:0] shift_out;
    logic       shift_carry;
    logic [7:0] sp_inc;
    logic [7:0] sp_dec;
    logic       nz_update;
    logic [7:0] nz_value;
    logic [5:0] flags_work;

    assign carry_in = cur.flags[FLAG_C];

    // Add with carry; subtract adds the complemented operand
    assign add_rhs = (dec.op == OP_SBC) ? ~operand_value : operand_value;
    assign add_sum = {1'b0, cur.acc} + {1'b0, add_rhs} + {8'd0, carry_in};
    assign add_ovf = ~(cur.acc[7] ^ add_rhs[7]) & (cur.acc[7] ^ add_sum[7]);

    // Compare: carry out of r + ~m + 1 means r >= m
    always_comb begin
        case (dec.op)
            OP_CPX:  cmp_lhs = cur.idx_x;
            OP_CPY:  cmp_lhs = cur.idx_y;
            default: cmp_lhs = cur.acc;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_lhs} + {1'b0, ~operand_value} + 9'd1;

    // Shifter for accumulator and memory forms
    assign shift_src = (dec.op == OP_SHIFT_A) ? cur.acc : operand_value;
    always_comb begin
        case (dec.shift_kind)
            SHIFT_ASL: begin
                shift_out   = {shift_src[6:0], 1'b0};
                shift_carry = shift_src[7];
            end
            SHIFT_ROL: begin
                shift_out   = {shift_src[6:0], carry_in};
                shift_carry = shift_src[7];
            end
            SHIFT_LSR: begin
                shift_out   = {1'b0, shift_src[7:1]};
                shift_carry = shift_src[0];
            end
            default: begin
                shift_out   = {carry_in, shift_src[7:1]};
                shift_carry = shift_src[0];
            end
        endcase
    end

    assign sp_inc = cur.sp + 8'd1;
    assign sp_dec = cur.sp - 8'd1;

    // Execute the operation
    always_comb begin
        nxt        = cur;
        flags_work = cur.flags;
        nz_update  = 1'b0;
        nz_value   = 8'd0;

        res.write_data    = 8'd0;
        res.write_enable  = 1'b0;
        res.stack_address = {STACK_PAGE, cur.sp};
        res.stack_access  = STACK_NONE;
        res.branch_taken  = 1'b0;
        res.branch_offset = 8'sd0;
        res.unsupported   = 1'b0;

        case (dec.op)
            OP_LDA: begin
                nxt.acc = operand_value; nz_update = 1'b1; nz_value = operand_value;
            end
            OP_LDX: begin
                nxt.idx_x = operand_value; nz_update = 1'b1; nz_value = operand_value;
            end
            OP_LDY: begin
                nxt.idx_y = operand_value; nz_update = 1'b1; nz_value = operand_value;
            end
            OP_STA: begin
                res.write_data = cur.acc; res.write_enable = 1'b1;
            end
            OP_STX: begin
                res.write_data = cur.idx_x; res.write_enable = 1'b1;
            end
            OP_STY: begin
                res.write_data = cur.idx_y; res.write_enable = 1'b1;
            end
            OP_ORA: begin
                nxt.acc = cur.acc | operand_value; nz_update = 1'b1; nz_value = nxt.acc;
            end
            OP_AND: begin
                nxt.acc = cur.acc & operand_value; nz_update = 1'b1; nz_value = nxt.acc;
            end
            OP_EOR: begin
                nxt.acc = cur.acc ^ operand_value; nz_update = 1'b1; nz_value = nxt.acc;
            end
            OP_ADC, OP_SBC: begin
                nxt.acc            = add_sum[7:0];
                flags_work[FLAG_C] = add_sum[8];
                flags_work[FLAG_V] = add_ovf;
                nz_update          = 1'b1;
                nz_value           = add_sum[7:0];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                flags_work[FLAG_C] = cmp_diff[8];
                nz_update          = 1'b1;
                nz_value           = cmp_diff[7:0];
            end
            OP_BIT: begin
                flags_work[FLAG_N] = operand_value[7];
                flags_work[FLAG_V] = operand_value[6];
                flags_work[FLAG_Z] = ((cur.acc & operand_value) == 8'd0);
            end
            OP_SHIFT_A: begin
                nxt.acc            = shift_out;
                flags_work[FLAG_C] = shift_carry;
                nz_update          = 1'b1;
                nz_value           = shift_out;
            end
            OP_SHIFT_M: begin
                res.write_data     = shift_out;
                res.write_enable   = 1'b1;
                flags_work[FLAG_C] = shift_carry;
                nz_update          = 1'b1;
                nz_value           = shift_out;
            end
            OP_INC: begin
                res.write_data   = operand_value + 8'd1;
                res.write_enable = 1'b1;
                nz_update        = 1'b1;
                nz_value         = res.write_data;
            end
            OP_DEC: begin
                res.write_data   = operand_value - 8'd1;
                res.write_enable = 1'b1;
                nz_update        = 1'b1;
                nz_value         = res.write_data;
            end
            OP_INX: begin
                nxt.idx_x = cur.idx_x + 8'd1; nz_update = 1'b1; nz_value = nxt.idx_x;
            end
            OP_INY: begin
                nxt.idx_y = cur.idx_y + 8'd1; nz_update = 1'b1; nz_value = nxt.idx_y;
            end
            OP_DEX: begin
                nxt.idx_x = cur.idx_x - 8'd1; nz_update = 1'b1; nz_value = nxt.idx_x;
            end
            OP_DEY: begin
                nxt.idx_y = cur.idx_y - 8'd1; nz_update = 1'b1; nz_value = nxt.idx_y;
            end
            OP_TAX: begin
                nxt.idx_x = cur.acc; nz_update = 1'b1; nz_value = cur.acc;
            end
            OP_TAY: begin
                nxt.idx_y = cur.acc; nz_update = 1'b1; nz_value = cur.acc;
            end
            OP_TXA: begin
                nxt.acc = cur.idx_x; nz_update = 1'b1; nz_value = cur.idx_x;
            end
            OP_TYA: begin
                nxt.acc = cur.idx_y; nz_update = 1'b1; nz_value = cur.idx_y;
            end
            OP_TSX: begin
                nxt.idx_x = cur.sp; nz_update = 1'b1; nz_value = cur.sp;
            end
            OP_TXS: begin
                nxt.sp            = cur.idx_x;
                res.stack_address = {STACK_PAGE, cur.idx_x};
            end
            OP_PHA, OP_PHP: begin
                res.write_data   = (dec.op == OP_PHA) ? cur.acc :
                                   {cur.flags[FLAG_N], cur.flags[FLAG_V], 2'b11,
                                    cur.flags[FLAG_D:FLAG_C]};
                res.write_enable = 1'b1;
                res.stack_access = STACK_PUSH;
                nxt.sp           = sp_dec;
            end
            OP_PLA: begin
                nxt.sp            = sp_inc;
                res.stack_address = {STACK_PAGE, sp_inc};
                res.stack_access  = STACK_POP;
                nxt.acc           = operand_value;
                nz_update         = 1'b1;
                nz_value          = operand_value;
            end
            OP_PLP: begin
                nxt.sp            = sp_inc;
                res.stack_address = {STACK_PAGE, sp_inc};
                res.stack_access  = STACK_POP;
                // Bits 4 and 5 of the popped byte carry no flag
                flags_work        = {operand_value[7:6], operand_value[3:0]};
            end
            OP_FLAG: begin
                flags_work[dec.flag_idx] = dec.flag_val;
            end
            OP_BRANCH: begin
                res.branch_taken  = (cur.flags[dec.flag_idx] == dec.flag_val);
                res.branch_offset = signed'(operand_value);
            end
            OP_NOP: begin
                nxt = cur;
            end
            default: begin
                res.unsupported = 1'b1;
            end
        endcase

        // Apply zero and negative from the result value
        if (nz_update) begin
            flags_work[FLAG_Z] = (nz_value == 8'd0);
            flags_work[FLAG_N] = nz_value[7];
        end
        nxt.flags = flags_work;

        res.status_byte = {flags_work[FLAG_N], flags_work[FLAG_V], 2'b10,
                           flags_work[FLAG_D:FLAG_C]};
    end

endmodule

// ===== rtl/cpu_6502_execute_unit_top.sv =====
// Path: input register, then result register. Throughput: one instruction per cycle
// while m_tready does not stall the output; the input register, the single-pass
// execute logic and the result register each move one transaction per cycle.
// The execute logic reads A, X, Y, S and the flags and writes them back in the
// same cycle, so consecutive instructions see each other's results directly.
// Reset: A, X, Y cleared, S = 0xFD, only the interrupt-disable flag set.
// ============================================================================
// cpu_6502_execute_unit_top - 6502 instruction execute unit
// Executes one documented opcode per input transaction in binary mode and
// returns store data, stack access, branch decision and the status byte.
// ============================================================================
module cpu_6502_execute_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] opcode, [15:8] operand_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] write_data, [8] write_enable,
                                   // [17:9] stack_address, [19:18] stack_access,
                                   // [20] branch_taken, [28:21] branch_offset,
                                   // [36:29] status_byte, [39:37] zero
    output logic [0:0]  m_tuser    // [0] unsupported
);
    import c6502eu_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_opcode_reg;
    logic [7:0] in_operand_reg;
    arch_t      arch_reg;
    arch_t      arch_next;
    logic       out_valid_reg;
    res_t       out_res_reg;
    res_t       res_next;
    dec_t       dec;
    logic       advance;
    logic       s_accept;

    // Execute when an instruction is held and the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    c6502eu_decode u_decode (
        .opcode (in_opcode_reg),
        .dec    (dec)
    );

    c6502eu_alu u_alu (
        .dec           (dec),
        .operand_value (in_operand_reg),
        .cur           (arch_reg),
        .nxt           (arch_next),
        .res           (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_accept) begin
            in_opcode_reg  <= s_tdata[7:0];
            in_operand_reg <= s_tdata[15:8];
        end
    end

    // Architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_reg.acc   <= 8'd0;
            arch_reg.idx_x <= 8'd0;
            arch_reg.idx_y <= 8'd0;
            arch_reg.sp    <= SP_RESET;
            arch_reg.flags <= FLAGS_RESET;
        end else if (advance) begin
            arch_reg <= arch_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.status_byte,
                       out_res_reg.branch_offset,
                       out_res_reg.branch_taken,
                       out_res_reg.stack_access,
                       out_res_reg.stack_address,
                       out_res_reg.write_enable,
                       out_res_reg.write_data};
    assign m_tuser  = out_res_reg.unsupported;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - self-checking bench for the 6502 execute unit
// A predictor of the 6502 execute stage runs on every accepted input
// transaction, covering registers, flags and stack pointer. Each result is
// checked field by field against the oldest prediction. Directed
// instructions come first, then random ones, with idling on both sides.
// ============================================================================
module testbench;
    import c6502eu_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned DRAIN_POINT  = 400;
    localparam int unsigned TAIL_CYCLES  = 8;

    // Opcodes used by the directed part
    localparam logic [7:0] OPC_LDA_IMM   = 8'hA9;
    localparam logic [7:0] OPC_ADC_IMM   = 8'h69;
    localparam logic [7:0] OPC_SBC_IMM   = 8'hE9;
    localparam logic [7:0] OPC_CMP_IMM   = 8'hC9;
    localparam logic [7:0] OPC_CPX_IMM   = 8'hE0;
    localparam logic [7:0] OPC_LDX_IMM   = 8'hA2;
    localparam logic [7:0] OPC_LSR_A     = 8'h4A;
    localparam logic [7:0] OPC_BCS       = 8'hB0;
    localparam logic [7:0] OPC_BIT_ZP    = 8'h24;
    localparam logic [7:0] OPC_PHP       = 8'h08;
    localparam logic [7:0] OPC_PLP       = 8'h28;
    localparam logic [7:0] OPC_PLA       = 8'h68;
    localparam logic [7:0] OPC_TXS       = 8'h9A;
    localparam logic [7:0] OPC_SEC       = 8'h38;
    localparam logic [7:0] OPC_SED       = 8'hF8;
    localparam logic [7:0] OPC_INC_ZP    = 8'hE6;
    localparam logic [7:0] OPC_STA_ZP    = 8'h85;
    localparam logic [7:0] OPC_NOP       = 8'hEA;
    localparam logic [7:0] OPC_BRK       = 8'h00;
    localparam logic [7:0] OPC_JMP_ABS   = 8'h4C;
    localparam logic [7:0] OPC_UNDEFINED = 8'hFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] opcode, [15:8] operand_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [7:0] write_data, [8] write_enable,
                                    // [17:9] stack_address, [19:18] stack_access,
                                    // [20] branch_taken, [28:21] branch_offset,
                                    // [36:29] status_byte, [39:37] zero
    logic [0:0]  m_tuser;           // [0] unsupported

    // Predicted architectural state
    logic [7:0] reg_a     = '0;
    logic [7:0] reg_x     = '0;
    logic [7:0] reg_y     = '0;
    logic [7:0] reg_sp    = SP_RESET;
    logic [5:0] flag_word = FLAGS_RESET;

    logic [15:0] instr_queue[$];
    res_t        predicted_results[$];
    int unsigned total_items  = 0;
    int unsigned sent_cnt     = 0;
    int unsigned accepted_cnt = 0;
    int unsigned checked_cnt  = 0;
    int unsigned error_cnt    = 0;
    int unsigned cycle_cnt    = 0;
    logic        drained      = 1'b0;

    cpu_6502_execute_unit_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Opcode table: documented opcodes by class, everything else unsupported
    function automatic op_class_t decode_opcode(input logic [7:0] opc);
        op_class_t cls;
        case (opc)
            8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: cls = OP_LDA;
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE:                      cls = OP_LDX;
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC:                      cls = OP_LDY;
            8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91:        cls = OP_STA;
            8'h86, 8'h96, 8'h8E:                                    cls = OP_STX;
            8'h84, 8'h94, 8'h8C:                                    cls = OP_STY;
            8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: cls = OP_ORA;
            8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: cls = OP_AND;
            8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: cls = OP_EOR;
            8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: cls = OP_ADC;
            8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: cls = OP_SBC;
            8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: cls = OP_CMP;
            8'hE0, 8'hE4, 8'hEC:                                    cls = OP_CPX;
            8'hC0, 8'hC4, 8'hCC:                                    cls = OP_CPY;
            8'h24, 8'h2C:                                           cls = OP_BIT;
            8'h0A, 8'h2A, 8'h4A, 8'h6A:                             cls = OP_SHIFT_A;
            8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
            8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: cls = OP_SHIFT_M;
            8'hE6, 8'hF6, 8'hEE, 8'hFE:                             cls = OP_INC;
            8'hC6, 8'hD6, 8'hCE, 8'hDE:                             cls = OP_DEC;
            8'hE8: cls = OP_INX;
            8'hC8: cls = OP_INY;
            8'hCA: cls = OP_DEX;
            8'h88: cls = OP_DEY;
            8'hAA: cls = OP_TAX;
            8'hA8: cls = OP_TAY;
            8'h8A: cls = OP_TXA;
            8'h98: cls = OP_TYA;
            8'hBA: cls = OP_TSX;
            8'h9A: cls = OP_TXS;
            8'h48: cls = OP_PHA;
            8'h08: cls = OP_PHP;
            8'h68: cls = OP_PLA;
            8'h28: cls = OP_PLP;
            8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8:        cls = OP_FLAG;
            8'hEA: cls = OP_NOP;
            8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: cls = OP_BRANCH;
            default: cls = OP_UNSUP;
        endcase
        return cls;
    endfunction

    // Update zero and negative from a result byte and pass it through
    function automatic logic [7:0] set_zn(input logic [7:0] v);
        flag_word[FLAG_Z] = (v == 8'h00);
        flag_word[FLAG_N] = v[7];
        return v;
    endfunction

    function automatic logic [7:0] status_byte_of();
        return {flag_word[FLAG_N], flag_word[FLAG_V], 1'b1, 1'b0,
                flag_word[FLAG_D], flag_word[FLAG_I], flag_word[FLAG_Z], flag_word[FLAG_C]};
    endfunction

    // Execute one instruction on the predicted state and build its result
    task automatic execute_opcode(input logic [7:0] opc, input logic [7:0] opnd,
                                  output res_t r);
        op_class_t  cls;
        logic [7:0] src;
        logic [7:0] val;
        logic [7:0] addend;
        logic [8:0] sum;
        logic [1:0] kind;
        logic       carry_in;
        logic       tested;
        cls = decode_opcode(opc);
        r = '0;
        r.stack_address = {STACK_PAGE, reg_sp};
        case (cls)
            OP_LDA: reg_a = set_zn(opnd);
            OP_LDX: reg_x = set_zn(opnd);
            OP_LDY: reg_y = set_zn(opnd);
            OP_STA: begin r.write_data = reg_a; r.write_enable = 1'b1; end
            OP_STX: begin r.write_data = reg_x; r.write_enable = 1'b1; end
            OP_STY: begin r.write_data = reg_y; r.write_enable = 1'b1; end
            OP_ORA: reg_a = set_zn(reg_a | opnd);
            OP_AND: reg_a = set_zn(reg_a & opnd);
            OP_EOR: reg_a = set_zn(reg_a ^ opnd);
            OP_ADC, OP_SBC: begin
                // Binary only: subtract adds the inverted operand
                addend = (cls == OP_SBC) ? ~opnd : opnd;
                sum = {1'b0, reg_a} + {1'b0, addend} + {8'h00, flag_word[FLAG_C]};
                flag_word[FLAG_C] = sum[8];
                flag_word[FLAG_V] = (reg_a[7] == addend[7]) && (sum[7] != reg_a[7]);
                reg_a = set_zn(sum[7:0]);
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                src = (cls == OP_CMP) ? reg_a : (cls == OP_CPX) ? reg_x : reg_y;
                flag_word[FLAG_C] = (src >= opnd);
                val = set_zn(src - opnd);
            end
            OP_BIT: begin
                flag_word[FLAG_N] = opnd[7];
                flag_word[FLAG_V] = opnd[6];
                flag_word[FLAG_Z] = ((reg_a & opnd) == 8'h00);
            end
            OP_SHIFT_A, OP_SHIFT_M: begin
                src = (cls == OP_SHIFT_A) ? reg_a : opnd;
                kind = opc[6:5];
                carry_in = flag_word[FLAG_C];
                if (kind == SHIFT_ASL || kind == SHIFT_ROL) begin
                    flag_word[FLAG_C] = src[7];
                    val = {src[6:0], (kind == SHIFT_ROL) ? carry_in : 1'b0};
                end else begin
                    flag_word[FLAG_C] = src[0];
                    val = {(kind == SHIFT_ROR) ? carry_in : 1'b0, src[7:1]};
                end
                val = set_zn(val);
                if (cls == OP_SHIFT_A) begin
                    reg_a = val;
                end else begin
                    r.write_data = val;
                    r.write_enable = 1'b1;
                end
            end
            OP_INC: begin r.write_data = set_zn(opnd + 8'd1); r.write_enable = 1'b1; end
            OP_DEC: begin r.write_data = set_zn(opnd - 8'd1); r.write_enable = 1'b1; end
            OP_INX: reg_x = set_zn(reg_x + 8'd1);
            OP_INY: reg_y = set_zn(reg_y + 8'd1);
            OP_DEX: reg_x = set_zn(reg_x - 8'd1);
            OP_DEY: reg_y = set_zn(reg_y - 8'd1);
            OP_TAX: reg_x = set_zn(reg_a);
            OP_TAY: reg_y = set_zn(reg_a);
            OP_TXA: reg_a = set_zn(reg_x);
            OP_TYA: reg_a = set_zn(reg_y);
            OP_TSX: reg_x = set_zn(reg_sp);
            OP_TXS: begin
                reg_sp = reg_x;
                r.stack_address = {STACK_PAGE, reg_sp};
            end
            OP_PHA, OP_PHP: begin
                // Push at the current slot, then move the pointer down
                r.write_data = (cls == OP_PHA) ? reg_a : (status_byte_of() | 8'h30);
                r.write_enable = 1'b1;
                r.stack_access = STACK_PUSH;
                reg_sp = reg_sp - 8'd1;
            end
            OP_PLA, OP_PLP: begin
                // Move the pointer up first, then read that slot
                reg_sp = reg_sp + 8'd1;
                r.stack_address = {STACK_PAGE, reg_sp};
                r.stack_access = STACK_POP;
                if (cls == OP_PLA) begin
                    reg_a = set_zn(opnd);
                end else begin
                    flag_word = {opnd[7], opnd[6], opnd[3:0]};
                end
            end
            OP_FLAG: begin
                // Bits 7:6 pick the flag, bit 5 the value; overflow can only be cleared
                case (opc[7:6])
                    2'b00: flag_word[FLAG_C] = opc[5];
                    2'b01: flag_word[FLAG_I] = opc[5];
                    2'b10: flag_word[FLAG_V] = 1'b0;
                    default: flag_word[FLAG_D] = opc[5];
                endcase
            end
            OP_BRANCH: begin
                case (opc[7:6])
                    2'b00: tested = flag_word[FLAG_N];
                    2'b01: tested = flag_word[FLAG_V];
                    2'b10: tested = flag_word[FLAG_C];
                    default: tested = flag_word[FLAG_Z];
                endcase
                r.branch_taken = (tested == opc[5]);
                r.branch_offset = opnd;
            end
            OP_NOP: ;
            default: r.unsupported = 1'b1;
        endcase
        r.status_byte = status_byte_of();
    endtask

    // Random instruction, weighted towards documented opcodes and edge operands
    function automatic logic [15:0] random_item();
        logic [7:0] opc;
        logic [7:0] opnd;
        opc = 8'($urandom_range(0, 255));
        while (decode_opcode(opc) == OP_UNSUP && $urandom_range(0, 99) < 85)
            opc = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: opnd = 8'h00;
            1: opnd = 8'hFF;
            2: opnd = 8'h80;
            3: opnd = 8'h7F;
            default: opnd = 8'($urandom_range(0, 255));
        endcase
        return {opnd, opc};
    endfunction

    task automatic check_field(input string name, input logic [8:0] exp_v,
                               input logic [8:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            error_cnt++;
        end
    endtask

    // Driver: present queued instructions, idling by phase
    always @(posedge aclk) begin
        int unsigned idle_pct;
        idle_pct = (sent_cnt < total_items / 3) ? 24 :
                   (sent_cnt < 2 * total_items / 3) ? 83 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the transaction until it is taken
        end else if (instr_queue.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (sent_cnt == DRAIN_POINT && !drained) begin
            // Pause until every outstanding result has returned
            s_tvalid <= 1'b0;
            if (!s_tvalid && accepted_cnt == checked_cnt)
                drained <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= instr_queue.pop_front();
            sent_cnt <= sent_cnt + 1;
        end
    end

    // Monitor: check results, then predict accepted instructions
    always @(posedge aclk) begin
        res_t        want;
        res_t        pred;
        int unsigned idle_pct;
        idle_pct = (checked_cnt < total_items / 3) ? 83 :
                   (checked_cnt < 2 * total_items / 3) ? 24 : 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with no prediction, expected none actual %h/%h",
                             $time, m_tdata, m_tuser);
                    error_cnt++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("write_data", {1'b0, want.write_data},
                                {1'b0, m_tdata[7:0]});
                    check_field("write_enable", {8'd0, want.write_enable},
                                {8'd0, m_tdata[8]});
                    check_field("stack_address", want.stack_address, m_tdata[17:9]);
                    check_field("stack_access", {7'd0, want.stack_access},
                                {7'd0, m_tdata[19:18]});
                    check_field("branch_taken", {8'd0, want.branch_taken},
                                {8'd0, m_tdata[20]});
                    check_field("branch_offset", {1'b0, want.branch_offset},
                                {1'b0, m_tdata[28:21]});
                    check_field("status_byte", {1'b0, want.status_byte},
                                {1'b0, m_tdata[36:29]});
                    check_field("unsupported", {8'd0, want.unsupported},
                                {8'd0, m_tuser[0]});
                    checked_cnt <= checked_cnt + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                execute_opcode(s_tdata[7:0], s_tdata[15:8], pred);
                predicted_results.push_back(pred);
                accepted_cnt <= accepted_cnt + 1;
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Directed: flag corner cases, stack, branches, unsupported opcodes
        instr_queue.push_back({8'h00, OPC_LDA_IMM});   // zero flag
        instr_queue.push_back({8'h7F, OPC_LDA_IMM});
        instr_queue.push_back({8'h01, OPC_ADC_IMM});   // signed overflow into negative
        instr_queue.push_back({8'hFF, OPC_ADC_IMM});   // carry out, overflow
        instr_queue.push_back({8'h00, OPC_SEC});
        instr_queue.push_back({8'h80, OPC_SBC_IMM});
        instr_queue.push_back({8'hFF, OPC_CMP_IMM});   // compare equal, carry set
        instr_queue.push_back({8'h00, OPC_CPX_IMM});   // equal: carry and zero
        instr_queue.push_back({8'h80, OPC_LDX_IMM});   // load X negative
        instr_queue.push_back({8'h01, OPC_LDA_IMM});
        instr_queue.push_back({8'hA5, OPC_LSR_A});     // shift A to zero
        instr_queue.push_back({8'h80, OPC_BCS});       // taken, most negative offset
        instr_queue.push_back({8'hC0, OPC_BIT_ZP});
        instr_queue.push_back({8'hFF, OPC_PHP});       // pushed byte has bits 4 and 5
        instr_queue.push_back({8'hFF, OPC_PLP});       // bits 4 and 5 dropped
        instr_queue.push_back({8'h00, OPC_PLA});
        instr_queue.push_back({8'h00, OPC_TXS});
        instr_queue.push_back({8'h00, OPC_SED});
        instr_queue.push_back({8'h09, OPC_ADC_IMM});   // still binary with decimal set
        instr_queue.push_back({8'hFF, OPC_INC_ZP});    // wraps to zero
        instr_queue.push_back({8'h3C, OPC_STA_ZP});
        instr_queue.push_back({8'hFF, OPC_NOP});
        instr_queue.push_back({8'h00, OPC_BRK});
        instr_queue.push_back({8'h4C, OPC_JMP_ABS});
        instr_queue.push_back({8'h80, OPC_UNDEFINED});
        repeat (RANDOM_ITEMS) instr_queue.push_back(random_item());
        total_items = instr_queue.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain, then let the pipeline settle
        @(negedge aclk);
        while (instr_queue.size() != 0 || s_tvalid || accepted_cnt != checked_cnt)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (predicted_results.size() != 0) begin
            $display("%0t: %0d predictions left without a result", $time,
                     predicted_results.size());
            error_cnt++;
        end
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/c6502eu_pkg.sv
rtl/c6502eu_decode.sv
rtl/c6502eu_alu.sv
rtl/cpu_6502_execute_unit_top.sv
verif/testbench.sv
